>>> design/tcb_pkg.sv
// Shared definitions for the text console buffer engine: default geometry,
// the reset attribute and the request codes. No dependencies.
package tcb_pkg;

  localparam int COLS_DEFAULT = 80;
  localparam int ROWS_DEFAULT = 25;

  localparam logic [7:0] ATTR_RESET = 8'h07;

  typedef enum logic [2:0] {
    REQ_PUT   = 3'd0,
    REQ_LINE  = 3'd1,
    REQ_DEL   = 3'd2,
    REQ_CLEAR = 3'd3,
    REQ_SET   = 3'd4,
    REQ_READ  = 3'd5
  } req_t;

endpackage

>>> design/tcb_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Depends on nothing.
module tcb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/text_console_buffer_engine.sv
// Text console buffer engine: ROWS x COLS cells in one RAM with a cursor.
// Put glyph (unless it scrolls at the last cell), set cursor, unused codes and delete at
// the first cell go straight to the result; delete elsewhere and read cell pass a RAM read
// first. Line break finds the row start by repeated subtraction, or scrolls from the last row.
// Scroll: one RAM copy or fill per cycle; clear: a fill pass over all cells.
// One item at a time; the next item is taken while a result waits in the output register.
// Synchronous reset; a clearing pass over every cell follows, no item accepted meanwhile.
module text_console_buffer_engine #(
  parameter int COLS = tcb_pkg::COLS_DEFAULT,
  parameter int ROWS = tcb_pkg::ROWS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  text_attribute,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [7:0]  glyph,
  input  logic [10:0] position,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] cell_data,
  output logic [10:0] cursor_index
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = ((AW > 11) ? AW : 11) + 1;

  localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_ROW  = AW'((ROWS - 1) * COLS);
  localparam logic [AW-1:0] COLS_A    = AW'(COLS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_LB,
    S_SCR,
    S_BLK,
    S_DONE
  } state_t;

  state_t          state;
  tcb_pkg::req_t   op;
  logic [7:0]      attr;
  logic [AW-1:0]   cursor;
  logic [AW-1:0]   idx;        // sweep index for copy and fill passes
  logic [AW-1:0]   rem;        // remainder while searching for the row start
  logic [AW-1:0]   row_base;
  logic [15:0]     fill;       // value written by a fill pass
  logic            pend;       // a copied cell awaits its write-back
  logic [AW-1:0]   pend_addr;
  logic            item_live;  // the running pass belongs to an item
  logic [15:0]     result;

  // RAM ports
  logic            we;
  logic [AW-1:0]   waddr;
  logic [15:0]     wdata;
  logic            re;
  logic [AW-1:0]   raddr;
  logic [15:0]     rdata;

  logic [AW-1:0]   pos_clamped;
  tcb_pkg::req_t   req;
  logic            accept;

  // The configuration register may be written at any time, including during
  // the clearing pass after reset.
  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign req       = tcb_pkg::req_t'(req_type);

  // Positions beyond the last cell saturate to it.
  assign pos_clamped = (CW'(position) >= CW'(CELLS)) ? CELL_LAST : AW'(position);

  tcb_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // RAM access per state. A put glyph writes in its accept cycle, so any
  // scroll that follows reads the cell only after that write has landed.
  always_comb begin
    we    = 1'b0;
    waddr = cursor;
    wdata = {attr, glyph};
    re    = 1'b0;
    raddr = pos_clamped;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (req)
            tcb_pkg::REQ_PUT: begin
              we = 1'b1;
            end
            tcb_pkg::REQ_DEL: begin
              re    = (cursor != '0);
              raddr = cursor - AW'(1);
            end
            tcb_pkg::REQ_READ: begin
              re = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        // Delete keeps the attribute and clears the character byte.
        if (op == tcb_pkg::REQ_DEL) begin
          we    = 1'b1;
          wdata = {rdata[15:8], 8'h00};
        end
      end
      S_SCR: begin
        // Read one row ahead and write back the cell read the cycle before.
        // The write address always trails the read address by more than a
        // row, so the two never meet.
        re    = 1'b1;
        raddr = idx + COLS_A;
        we    = pend;
        waddr = pend_addr;
        wdata = rdata;
      end
      S_BLK: begin
        we = 1'b1;
        if (pend) begin
          waddr = pend_addr;
          wdata = rdata;
        end else begin
          waddr = idx;
          wdata = fill;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_BLK;
      op        <= tcb_pkg::REQ_PUT;
      attr      <= tcb_pkg::ATTR_RESET;
      cursor    <= '0;
      idx       <= '0;
      fill      <= 16'h0000;
      pend      <= 1'b0;
      item_live <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        attr <= text_attribute;
      end
      // The output register is loaded when the result is ready and the
      // register is free or being emptied in the same cycle.
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op        <= req;
            result    <= 16'h0000;
            item_live <= 1'b1;
            fill      <= {attr, 8'h00};
            idx       <= '0;
            pend      <= 1'b0;
            case (req)
              tcb_pkg::REQ_PUT: begin
                if (cursor == CELL_LAST) begin
                  cursor <= LAST_ROW;
                  state  <= S_SCR;
                end else begin
                  cursor <= cursor + AW'(1);
                  state  <= S_DONE;
                end
              end
              tcb_pkg::REQ_LINE: begin
                if (cursor < LAST_ROW) begin
                  rem      <= cursor;
                  row_base <= '0;
                  state    <= S_LB;
                end else begin
                  cursor <= LAST_ROW;
                  state  <= S_SCR;
                end
              end
              tcb_pkg::REQ_DEL: begin
                // Delete at the first cell changes nothing.
                if (cursor != '0) begin
                  cursor <= cursor - AW'(1);
                  state  <= S_RD;
                end else begin
                  state <= S_DONE;
                end
              end
              tcb_pkg::REQ_CLEAR: begin
                cursor <= '0;
                state  <= S_BLK;
              end
              tcb_pkg::REQ_SET: begin
                cursor <= pos_clamped;
                state  <= S_DONE;
              end
              tcb_pkg::REQ_READ: begin
                state <= S_RD;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_RD: begin
          if (op == tcb_pkg::REQ_READ) begin
            result <= rdata;
          end
          state <= S_DONE;
        end
        S_LB: begin
          // One subtraction per cycle; at most ROWS-2 of them.
          if (rem >= COLS_A) begin
            rem      <= rem - COLS_A;
            row_base <= row_base + COLS_A;
          end else begin
            cursor <= row_base + COLS_A;
            state  <= S_DONE;
          end
        end
        S_SCR: begin
          pend      <= 1'b1;
          pend_addr <= idx;
          if (idx == LAST_ROW - AW'(1)) begin
            idx   <= LAST_ROW;
            state <= S_BLK;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_BLK: begin
          if (pend) begin
            pend <= 1'b0;
          end else if (idx == CELL_LAST) begin
            state <= item_live ? S_DONE : S_IDLE;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            cell_data    <= result;
            cursor_index <= 11'(cursor);
            item_live    <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/tcb_checker.sv
// Port-level checks for the text console buffer engine, and the bind that
// attaches them to the top level. Depends on tcb_pkg and text_console_buffer_engine.
module tcb_checker #(
  parameter int COLS = tcb_pkg::COLS_DEFAULT,
  parameter int ROWS = tcb_pkg::ROWS_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] cell_data,
  input logic [10:0] cursor_index
);

  localparam int CELLS = COLS * ROWS;

  // No result comes out of reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  // A waiting result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_data) && $stable(cursor_index))
    else $error("result changed while stalled");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in progress");

  // The reported cursor stays on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CELLS > 2047) || (int'(cursor_index) < CELLS))
    else $error("cursor beyond the last cell");

endmodule

bind text_console_buffer_engine tcb_checker #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_tcb_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .cell_data    (cell_data),
  .cursor_index (cursor_index)
);
